>>> rtl/atce_pkg.sv
package atce_pkg;

  localparam logic [7:0] ESC_BYTE = 8'h1b;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LBR   = 8'h5b;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [15:0] ATTR_RESET = 16'h0007;
  localparam int unsigned ARG_CHAR_LIMIT = 10;

  localparam logic [2:0] CFG_COLS  = 3'd0;
  localparam logic [2:0] CFG_ROWS  = 3'd1;
  localparam logic [2:0] CFG_WRAP  = 3'd2;
  localparam logic [2:0] CFG_SCRL  = 3'd3;
  localparam logic [2:0] CFG_ANSI  = 3'd4;

  // Datapath commands issued by the controller
  typedef enum logic [2:0] {
    DP_NONE,
    DP_WRITE,
    DP_READ,
    DP_COPY_RD,
    DP_COPY_WR,
    DP_FILL
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [6:0] row;
    logic [7:0] col;
    logic [7:0] ch;
    logic [15:0] attr;
  } dp_cmd_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic [15:0] attr;
  } dp_stat_t;

  function automatic logic [15:0] sgr_apply(input logic [15:0] a, input logic [7:0] v);
    logic [2:0] col;
    logic [15:0] r;
    begin
      col = {v[0], v[1], v[2]};
      r = a;
      case (v)
        8'd0: r = ATTR_RESET;
        8'd1: r = a | 16'h1000;
        8'd4: r = a | 16'h2000;
        8'd5: r = a | 16'h4000;
        8'd7: r = a | 16'h8000;
        8'd8: r = a | 16'hA000;
        default: begin
          if (v >= 8'd30 && v <= 8'd37) begin
            col = 3'(v - 8'd30);
            r = (a & 16'hFF00) | {13'd0, col[0], col[1], col[2]};
          end else if (v >= 8'd40 && v <= 8'd47) begin
            col = 3'(v - 8'd40);
            r = (a & 16'hF0FF) | {5'd0, col[0], col[1], col[2], 8'd0};
          end
        end
      endcase
      return r;
    end
  endfunction

endpackage

>>> rtl/atce_datapath.sv
module atce_datapath #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 32
) (
  input  logic              clk,
  input  atce_pkg::dp_cmd_t cmd,
  output atce_pkg::dp_stat_t stat
);
  import atce_pkg::*;

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int CELLS = MAX_COLS * MAX_ROWS;

  logic [7:0]  char_mem [CELLS];
  logic [15:0] attr_mem [CELLS];
  logic [7:0]  hold_ch;
  logic [15:0] hold_attr;
  logic [RW+CW-1:0] addr;

  assign addr = {cmd.row[RW-1:0], cmd.col[CW-1:0]};

  // One port: read registered, or write held copy data / command data
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_WRITE, DP_FILL: begin
        char_mem[addr] <= cmd.ch;
        attr_mem[addr] <= cmd.attr;
      end
      DP_COPY_WR: begin
        char_mem[addr] <= hold_ch;
        attr_mem[addr] <= hold_attr;
      end
      DP_READ, DP_COPY_RD: begin
        hold_ch   <= char_mem[addr];
        hold_attr <= attr_mem[addr];
      end
      default: ;
    endcase
  end

  assign stat.ch   = hold_ch;
  assign stat.attr = hold_attr;
endmodule

>>> rtl/atce_ctrl.sv
module atce_ctrl #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 32,
  parameter int MAX_ARGS = 10,
  parameter int ESCAPE_LIMIT = 50
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic req_type,
  input  logic [7:0] char_code,
  input  logic [4:0] read_row,
  input  logic [5:0] read_col,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [6:0] cfg_data,
  output logic out_valid,
  input  logic out_stall,
  output logic [7:0] cell_char,
  output logic [15:0] cell_attr,
  output logic [3:0] fg_palette,
  output logic [2:0] bg_palette,
  output logic [6:0] cursor_col,
  output logic [5:0] cursor_row,
  output logic in_escape,
  output logic write_dropped,
  output atce_pkg::dp_cmd_t cmd,
  input  atce_pkg::dp_stat_t stat
);
  import atce_pkg::*;

  localparam int AW = $clog2(MAX_ARGS + 1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_WRAP, S_SCROLL_RD, S_SCROLL_WR, S_ESC, S_CMD,
    S_SGR, S_FILL, S_PRINT, S_READ, S_READ_DONE, S_OUT
  } state_t;

  state_t state;
  logic [6:0] cols_cfg;
  logic [5:0] rows_cfg;
  logic wrap_en, scroll_en, ansi_en;
  logic [6:0] cx, sx;
  logic [6:0] cy, sy;
  logic [15:0] cur_attr;
  logic [5:0] esc_len;
  logic [7:0] args [MAX_ARGS];
  logic [AW-1:0] arg_cnt, sgr_idx;
  logic [3:0] dig_cnt;
  logic br_seen, frozen, stopped;
  logic [7:0] b;
  logic [7:0] wr, wc, fill_row_end;
  logic [6:0] fill_col0;
  logic fill_home;
  logic rd_ok;

  logic [7:0] nc, nr;
  always_comb begin
    nc = {1'b0, cols_cfg};
    if (nc == 8'd0) nc = 8'd1;
    if (nc > 8'(MAX_COLS)) nc = 8'(MAX_COLS);
    nr = {2'b0, rows_cfg};
    if (nr == 8'd0) nr = 8'd1;
    if (nr > 8'(MAX_ROWS)) nr = 8'(MAX_ROWS);
  end

  logic is_digit;
  assign is_digit = (b >= 8'h30 && b <= 8'h39);

  // Clamp helper in signed 10-bit space
  function automatic logic [6:0] clampv(input logic signed [9:0] v, input logic [7:0] n);
    logic signed [9:0] m;
    begin
      m = $signed({2'b0, n}) - 10'sd1;
      if (v < 0) return 7'd0;
      if (v > m) return m[6:0];
      return v[6:0];
    end
  endfunction

  logic [7:0] a0m;
  logic [7:0] sat_val;
  logic [11:0] mul10;
  assign a0m = (args[0] == 8'd0) ? 8'd1 : args[0];
  assign mul10 = {4'd0, args[arg_cnt[AW-1:0] < AW'(MAX_ARGS) ? arg_cnt : '0]} * 12'd10
                 + {8'd0, b[3:0]};
  assign sat_val = (mul10 > 12'd255) ? 8'd255 : mul10[7:0];

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT; wr <= '0; wc <= '0;
      cols_cfg <= 7'd64; rows_cfg <= 6'd32;
      wrap_en <= 1'b1; scroll_en <= 1'b1; ansi_en <= 1'b0;
      cx <= '0; cy <= '0; sx <= '0; sy <= '0;
      cur_attr <= ATTR_RESET; esc_len <= '0;
      for (int i = 0; i < MAX_ARGS; i++) args[i] <= '0;
      arg_cnt <= '0; dig_cnt <= '0; br_seen <= 1'b0; frozen <= 1'b0; stopped <= 1'b0;
      out_valid <= 1'b0; cmd.op <= DP_NONE;
    end else begin
      cmd.op <= DP_NONE;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_COLS: cols_cfg <= cfg_data;
          CFG_ROWS: rows_cfg <= cfg_data[5:0];
          CFG_WRAP: wrap_en <= cfg_data[0];
          CFG_SCRL: scroll_en <= cfg_data[0];
          CFG_ANSI: ansi_en <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (state)
        // Sweep the whole store to reset values
        S_INIT: begin
          cmd.op <= DP_FILL; cmd.row <= wr[6:0]; cmd.col <= wc;
          cmd.ch <= '0; cmd.attr <= ATTR_RESET;
          if (wc == 8'(MAX_COLS - 1)) begin
            wc <= '0; wr <= wr + 8'd1;
            if (wr == 8'(MAX_ROWS - 1)) state <= S_IDLE;
          end else wc <= wc + 8'd1;
        end
        S_IDLE: begin
          write_dropped <= 1'b0; cell_char <= '0; cell_attr <= '0;
          if (in_valid) begin
            b <= char_code;
            if (req_type) begin
              rd_ok <= ({3'b0, read_row} < nr) && ({2'b0, read_col} < nc);
              cmd.op <= DP_READ; cmd.row <= {2'b0, read_row}; cmd.col <= {2'b0, read_col};
              state <= S_READ;
            end else if (char_code == 8'd0) state <= S_OUT;
            else state <= S_WRAP;
          end
        end
        S_READ: state <= S_READ_DONE;
        S_READ_DONE: begin
          if (rd_ok) begin cell_char <= stat.ch; cell_attr <= stat.attr; end
          state <= S_OUT;
        end
        S_WRAP: begin
          if ({1'b0, cx} >= nc && wrap_en) begin
            cy <= (cy < 7'(MAX_ROWS)) ? cy + 7'd1 : 7'(MAX_ROWS);
            cx <= '0;
          end
          state <= S_CMD; wr <= '0; wc <= '0;
          // scroll check done next: reuse S_SCROLL_RD entry from S_CMD
        end
        S_SCROLL_RD: begin
          // copy row wr+1 to row wr, or blank the last row
          if (wr + 8'd1 < nr) begin
            cmd.op <= DP_COPY_RD; cmd.row <= 7'(wr + 8'd1); cmd.col <= wc;
            state <= S_SCROLL_WR;
          end else begin
            cmd.op <= DP_FILL; cmd.row <= wr[6:0]; cmd.col <= wc;
            cmd.ch <= '0; cmd.attr <= cur_attr;
            if (wc + 8'd1 >= nc) begin
              cy <= 7'(nr - 8'd1); state <= S_ESC;
            end else wc <= wc + 8'd1;
          end
        end
        S_SCROLL_WR: begin
          cmd.op <= DP_COPY_WR; cmd.row <= wr[6:0]; cmd.col <= wc;
          if (wc + 8'd1 >= nc) begin wc <= '0; wr <= wr + 8'd1; end
          else wc <= wc + 8'd1;
          state <= S_SCROLL_RD;
        end
        S_CMD: begin
          if ({1'b0, cy} >= nr && scroll_en) state <= S_SCROLL_RD;
          else state <= S_ESC;
        end
        S_ESC: begin
          state <= S_OUT;
          if (esc_len != '0) begin
            logic [5:0] pos;
            logic [5:0] len;
            logic st;
            logic [AW-1:0] ac;
            pos = esc_len; st = stopped;
            if (esc_len > 6'(ESCAPE_LIMIT)) begin
              pos = '0; st = 1'b0;
              for (int i = 0; i < MAX_ARGS; i++) args[i] <= '0;
              arg_cnt <= '0; dig_cnt <= '0; br_seen <= 1'b0; frozen <= 1'b0;
              stopped <= 1'b0;
            end
            len = pos + 6'd1;
            esc_len <= len;
            if (!is_digit && b != CH_LBR && b != CH_SEMI) begin
              esc_len <= '0;
              if (br_seen && esc_len <= 6'(ESCAPE_LIMIT)) begin
                ac = arg_cnt;
                if (!stopped && dig_cnt != 4'd0 && arg_cnt < AW'(MAX_ARGS))
                  ac = arg_cnt + AW'(1);
                arg_cnt <= ac;
                case (b)
                  8'h48, 8'h66: begin
                    if (ac == '0) begin cx <= '0; cy <= '0; end
                    else begin
                      cx <= clampv($signed({2'b0, args[1]}) - 10'sd1, nc);
                      cy <= clampv($signed({2'b0, args[0]}) - 10'sd1, nr);
                    end
                  end
                  8'h41: begin cx <= clampv($signed({3'b0, cx}), nc);
                    cy <= clampv($signed({3'b0, cy}) - $signed({2'b0, a0m}), nr); end
                  8'h42: begin cx <= clampv($signed({3'b0, cx}), nc);
                    cy <= clampv($signed({3'b0, cy}) + $signed({2'b0, a0m}), nr); end
                  8'h43: begin cy <= clampv($signed({3'b0, cy}), nr);
                    cx <= clampv($signed({3'b0, cx}) + $signed({2'b0, a0m}), nc); end
                  8'h44: begin cy <= clampv($signed({3'b0, cy}), nr);
                    cx <= clampv($signed({3'b0, cx}) - $signed({2'b0, a0m}), nc); end
                  8'h4A: begin
                    wr <= '0; wc <= '0; fill_row_end <= nr; fill_col0 <= '0;
                    fill_home <= 1'b1; state <= S_FILL;
                  end
                  8'h73: begin sx <= cx; sy <= cy; end
                  8'h75: begin cx <= sx; cy <= sy; sx <= '0; sy <= '0; end
                  8'h4B, 8'h6B: begin
                    if ({1'b0, cy} < nr && {1'b0, cx} < nc) begin
                      wr <= {1'b0, cy}; wc <= {1'b0, cx}; fill_col0 <= cx;
                      fill_row_end <= {1'b0, cy} + 8'd1; fill_home <= 1'b0;
                      state <= S_FILL;
                    end
                  end
                  8'h6D: begin sgr_idx <= '0; state <= S_SGR; end
                  default: ;
                endcase
              end
            end else if (pos == 6'd1) begin
              br_seen <= (b == CH_LBR);
            end else if (pos >= 6'd2 && !st) begin
              if (b == CH_SEMI) begin
                arg_cnt <= arg_cnt + AW'(1); dig_cnt <= '0; frozen <= 1'b0;
                if (arg_cnt + AW'(1) >= AW'(MAX_ARGS)) stopped <= 1'b1;
              end else begin
                dig_cnt <= dig_cnt + 4'd1;
                if (!frozen && arg_cnt < AW'(MAX_ARGS)) begin
                  if (is_digit) args[arg_cnt[AW-1:0]] <= sat_val;
                  else frozen <= 1'b1;
                end
                if (dig_cnt + 4'd1 >= 4'(ARG_CHAR_LIMIT)) begin
                  stopped <= 1'b1;
                  if (arg_cnt < AW'(MAX_ARGS)) arg_cnt <= arg_cnt + AW'(1);
                end
              end
            end
          end else if (b == ESC_BYTE && ansi_en) begin
            for (int i = 0; i < MAX_ARGS; i++) args[i] <= '0;
            arg_cnt <= '0; dig_cnt <= '0; br_seen <= 1'b0; frozen <= 1'b0;
            stopped <= 1'b0; esc_len <= 6'd1;
          end else if (b == CH_LF) begin
            cy <= (cy < 7'(MAX_ROWS)) ? cy + 7'd1 : 7'(MAX_ROWS); cx <= '0;
          end else if (b == CH_CR) cx <= '0;
          else if (b == CH_BS) begin
            if (cx != '0) cx <= cx - 7'd1;
          end else if ({1'b0, cx} < nc && {1'b0, cy} < nr) begin
            cmd.op <= DP_WRITE; cmd.row <= cy; cmd.col <= {1'b0, cx};
            cmd.ch <= b; cmd.attr <= cur_attr; cx <= cx + 7'd1;
          end else write_dropped <= 1'b1;
        end
        // Apply one SGR code a cycle
        S_SGR: begin
          if (sgr_idx < arg_cnt && sgr_idx < AW'(MAX_ARGS)) begin
            cur_attr <= sgr_apply(cur_attr, args[sgr_idx]);
            sgr_idx <= sgr_idx + AW'(1);
          end else state <= S_OUT;
        end
        S_FILL: begin
          cmd.op <= DP_FILL; cmd.row <= wr[6:0]; cmd.col <= wc;
          cmd.ch <= '0; cmd.attr <= cur_attr;
          if (wc + 8'd1 >= nc) begin
            wc <= {1'b0, fill_col0}; wr <= wr + 8'd1;
            if (wr + 8'd1 >= fill_row_end) begin
              if (fill_home) begin cx <= '0; cy <= '0; end
              state <= S_OUT;
            end
          end else wc <= wc + 8'd1;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          if (out_valid && !out_stall) begin
            out_valid <= 1'b0; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign fg_palette = {1'b0, cell_attr[2:0]} + (cell_attr[12] ? 4'd8 : 4'd0);
  assign bg_palette = cell_attr[10:8];
  assign cursor_col = cx;
  assign cursor_row = cy[5:0];
  assign in_escape = (esc_len != '0);
endmodule

>>> rtl/ansi_text_console_engine.sv
// Character-cell text terminal with an ANSI escape parser.
// Clear screen and clear line walk the cell memory one cell a cycle; scroll
// copies each cell by a read state then a write state, then blanks the last row.
// Throughput: one word per item, no overlap; input stalls during walks.
// Reset: synchronous; after reset a clearing pass over all MAX_ROWS*MAX_COLS
// cells fills the store before the first input word is taken.
module ansi_text_console_engine #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 32,
  parameter int MAX_ARGS = 10,
  parameter int ESCAPE_LIMIT = 50
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic req_type,
  input  logic [7:0] char_code,
  input  logic [4:0] read_row,
  input  logic [5:0] read_col,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [6:0] cfg_data,
  output logic out_valid,
  input  logic out_stall,
  output logic [7:0] cell_char,
  output logic [15:0] cell_attr,
  output logic [3:0] fg_palette,
  output logic [2:0] bg_palette,
  output logic [6:0] cursor_col,
  output logic [5:0] cursor_row,
  output logic in_escape,
  output logic write_dropped
);
  import atce_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Controller: parser, cursor and memory walks
  atce_ctrl #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .MAX_ARGS(MAX_ARGS),
              .ESCAPE_LIMIT(ESCAPE_LIMIT)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .req_type, .char_code, .read_row, .read_col,
    .cfg_we, .cfg_index, .cfg_data, .out_valid, .out_stall, .cell_char, .cell_attr,
    .fg_palette, .bg_palette, .cursor_col, .cursor_row, .in_escape, .write_dropped,
    .cmd, .stat
  );

  // Datapath: the cell store
  atce_datapath #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_dp (
    .clk, .cmd, .stat
  );
endmodule
